@@ rtl/bfm_pkg.sv @@
package bfm_pkg;

    localparam int PIX_W       = 8;
    localparam int PIX_MAX     = 255;
    localparam int ROW_W       = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int RADIUS_W    = 3;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd2048;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_reg_t;

    // Exact division by side^2 for sums below 2^18:
    // q = (sum * RECIP_TABLE[r]) >> RECIP_SHIFT, entry = floor(2^28 / side^2) + 1
    localparam int RIDX_W      = 4;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 28;

    typedef logic [RECIP_W-1:0] recip_t;

    localparam recip_t RECIP_TABLE [0:15] = '{
        29'd268435457, 29'd29826162, 29'd10737419, 29'd5478275,
        29'd3314018,   29'd2218475,  29'd1588376,  29'd1193047,
        29'd928843,    29'd743589,   29'd608698,   29'd507440,
        29'd429497,    29'd368225,   29'd319187,   29'd279330
    };

endpackage

@@ rtl/box_filter_mean.sv @@
// Streaming box filter: mean over a (2r+1)x(2r+1) window of 8-bit pixels.
// Pixels enter on in_valid/in_ready in raster order, one item per pixel.
// A result leaves on out_valid/out_ready for each pixel whose window lies
// fully in the image (rows and columns from 2r on); it carries the mean,
// rounded down, and the position of the window centre. frame_last marks
// the result of the last pixel of a frame.
// Registers are written on cfg_valid/cfg_ready (always ready): index 0 is
// the radius, 1 the width, 2 the height. A write restarts the frame.
// A result passes the stage 1, 2 and 3 registers and the divider's output
// register. Throughput: one pixel per cycle while out_ready lets results
// leave, set by the single read and single write per cycle on the
// column-sum and line-store memories; a read is issued as its pixel is
// taken, the write-back as it leaves stage 1, with forwarding when the
// next pixel hits the same entry. Reset: radius 1, 2048 x 2048, counters
// at row 0, column 0. The memories are not cleared; read data of an entry
// is used only after it is written. When out_ready is low the pipeline
// stages fill and then in_ready drops; empty stages still take new pixels.
module box_filter_mean #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bfm_pkg::PIX_W-1:0]          pixel,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bfm_pkg::PIX_W-1:0]          mean_value,
    output logic [bfm_pkg::ROW_W-1:0]          centre_row,
    output logic [$clog2(MAX_WIDTH)-1:0]       centre_col,
    output logic                               frame_last
);

    localparam int MAX_SIDE = 2 * MAX_RADIUS + 1;
    localparam int RW       = $clog2(MAX_RADIUS + 1);
    localparam int SW       = RW + 1;
    localparam int SLW      = $clog2(MAX_SIDE);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int CMPW     = (CW > SW) ? CW : SW;
    localparam int WCW      = (CW + 1 > bfm_pkg::WIDTH_W) ? CW + 1 : bfm_pkg::WIDTH_W;
    localparam int RCW      = (RW > bfm_pkg::RADIUS_W) ? RW : bfm_pkg::RADIUS_W;
    localparam int LS_DEPTH = MAX_SIDE * MAX_WIDTH;
    localparam int LAW      = $clog2(LS_DEPTH);
    localparam int CSW      = $clog2(MAX_SIDE * bfm_pkg::PIX_MAX + 1);
    localparam int HSW      = $clog2(MAX_SIDE * MAX_SIDE * bfm_pkg::PIX_MAX + 1);
    localparam int ROW_W    = bfm_pkg::ROW_W;
    localparam int PIX_W    = bfm_pkg::PIX_W;

    typedef struct packed {
        logic row_zero;
        logic row_ge_side;
        logic col_zero;
        logic col_ge_side;
        logic emit;
        logic last;
    } item_flags_t;

    // configuration
    logic [bfm_pkg::RADIUS_W-1:0] radius_reg;
    logic [bfm_pkg::WIDTH_W-1:0]  width_reg;
    logic [bfm_pkg::HEIGHT_W-1:0] height_reg;
    logic                         cfg_wr;
    logic                         cfg_restart;
    logic [RCW-1:0]               radius_ext;
    logic [RW-1:0]                r_eff;
    logic [SW-1:0]                side;
    logic [SW-1:0]                side_m1;
    logic [WCW-1:0]               width_ext;
    logic [CW-1:0]                w_last;
    logic [ROW_W-1:0]             h_last;

    // position counters
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SLW-1:0]   slot_reg, slot_next;
    logic [SLW-1:0]   cslot_reg, cslot_next;
    logic [LAW-1:0]   base_reg, base_next;
    logic             col_end, row_end;
    logic [LAW-1:0]   la0;
    item_flags_t      flags0;

    // handshake
    logic acc;
    logic div_ready;
    logic load3, load2, adv2, adv1;

    // stage 1: memory data
    logic              v1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [CW-1:0]     col1_reg;
    logic [LAW-1:0]    la1_reg;
    logic [SLW-1:0]    cslot1_reg;
    logic [ROW_W-1:0]  crow1_reg;
    logic [CW-1:0]     ccol1_reg;
    item_flags_t       flags1_reg;
    logic [CSW-1:0]    cs_q, cs_rd, cs1;
    logic [PIX_W-1:0]  ls_q, ls_rd;
    logic              fwd_cs_hit_reg, fwd_ls_hit_reg;
    logic [CSW-1:0]    fwd_cs_reg;
    logic [PIX_W-1:0]  fwd_ls_reg;

    // stage 2: horizontal sum
    logic              v2_reg;
    logic [CSW-1:0]    cs2_reg;
    logic [SLW-1:0]    cslot2_reg;
    logic [ROW_W-1:0]  crow2_reg;
    logic [CW-1:0]     ccol2_reg;
    item_flags_t       flags2_reg;
    logic [CSW-1:0]    recent_reg [MAX_SIDE];
    logic [HSW-1:0]    hsum_reg, hsum_next;

    // stage 3: window sum to the divider
    logic              v3_reg;
    logic [HSW-1:0]    sum3_reg;
    logic [ROW_W-1:0]  crow3_reg;
    logic [CW-1:0]     ccol3_reg;
    logic              last3_reg;

    // ---------------- configuration ----------------
    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_wr && ((cfg_index == bfm_pkg::CFG_RADIUS)
                                 || (cfg_index == bfm_pkg::CFG_WIDTH)
                                 || (cfg_index == bfm_pkg::CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= bfm_pkg::RADIUS_RESET;
            width_reg  <= bfm_pkg::WIDTH_RESET;
            height_reg <= bfm_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                bfm_pkg::CFG_RADIUS: radius_reg <= cfg_data[bfm_pkg::RADIUS_W-1:0];
                bfm_pkg::CFG_WIDTH:  width_reg  <= cfg_data[bfm_pkg::WIDTH_W-1:0];
                bfm_pkg::CFG_HEIGHT: height_reg <= cfg_data[bfm_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        radius_ext = RCW'(radius_reg);
        if (radius_ext > RCW'(MAX_RADIUS))
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(radius_ext);
        side    = {r_eff, 1'b1};
        side_m1 = {r_eff, 1'b0};

        width_ext = WCW'(width_reg);
        if (width_reg == '0)
            w_last = '0;
        else if (width_ext > WCW'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(width_ext - WCW'(1));

        if (height_reg == '0)
            h_last = '0;
        else if (height_reg > bfm_pkg::HEIGHT_W'(bfm_pkg::MAX_HEIGHT))
            h_last = ROW_W'(bfm_pkg::MAX_HEIGHT - 1);
        else
            h_last = ROW_W'(height_reg - bfm_pkg::HEIGHT_W'(1));
    end

    // ---------------- handshake ----------------
    assign load3    = !v3_reg || div_ready;
    assign adv2     = v2_reg && load3;
    assign load2    = !v2_reg || load3;
    assign adv1     = v1_reg && load2;
    assign in_ready = !v1_reg || load2;
    assign acc      = in_valid && in_ready;

    // ---------------- stage 0: position and read issue ----------------
    always_comb
    begin
        col_end    = (col_reg == w_last);
        row_end    = (row_reg == h_last);
        la0        = base_reg + LAW'(col_reg);

        col_next   = col_reg + CW'(1);
        cslot_next = (SW'(cslot_reg) == side_m1) ? '0 : cslot_reg + SLW'(1);
        row_next   = row_reg;
        slot_next  = slot_reg;
        base_next  = base_reg;
        if (col_end)
        begin
            col_next   = '0;
            cslot_next = '0;
            if (row_end)
            begin
                row_next  = '0;
                slot_next = '0;
                base_next = '0;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
                if (SW'(slot_reg) == side_m1)
                begin
                    slot_next = '0;
                    base_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLW'(1);
                    base_next = base_reg + LAW'(MAX_WIDTH);
                end
            end
        end

        flags0.row_zero    = (row_reg == '0);
        flags0.row_ge_side = (row_reg >= ROW_W'(side));
        flags0.col_zero    = (col_reg == '0);
        flags0.col_ge_side = (CMPW'(col_reg) >= CMPW'(side));
        flags0.emit        = (row_reg >= ROW_W'(side_m1)) && (CMPW'(col_reg) >= CMPW'(side_m1));
        flags0.last        = row_end && col_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            cslot_reg <= '0;
            base_reg  <= '0;
        end
        else if (cfg_restart)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            cslot_reg <= '0;
            base_reg  <= '0;
        end
        else if (acc)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            slot_reg  <= slot_next;
            cslot_reg <= cslot_next;
            base_reg  <= base_next;
        end
    end

    // ---------------- stage 1: column sum read-modify-write ----------------
    bfm_ram #(
        .WIDTH (CSW),
        .DEPTH (MAX_WIDTH)
    ) u_colsum_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (col1_reg),
        .wdata (cs1),
        .re    (acc),
        .raddr (col_reg),
        .rdata (cs_q)
    );

    bfm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LS_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (la1_reg),
        .wdata (pix1_reg),
        .re    (acc),
        .raddr (la0),
        .rdata (ls_q)
    );

    always_comb
    begin
        cs_rd = fwd_cs_hit_reg ? fwd_cs_reg : cs_q;
        ls_rd = fwd_ls_hit_reg ? fwd_ls_reg : ls_q;
        if (flags1_reg.row_zero)
            cs1 = CSW'(pix1_reg);
        else
            cs1 = cs_rd + CSW'(pix1_reg)
                - (flags1_reg.row_ge_side ? CSW'(ls_rd) : CSW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            fwd_cs_hit_reg <= 1'b0;
            fwd_ls_hit_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= in_valid;
            if (acc)
            begin
                // the item leaving stage 1 writes now; the new read misses it
                fwd_cs_hit_reg <= v1_reg && (col1_reg == col_reg);
                fwd_ls_hit_reg <= v1_reg && (la1_reg == la0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pix1_reg   <= pixel;
            col1_reg   <= col_reg;
            la1_reg    <= la0;
            cslot1_reg <= cslot_reg;
            crow1_reg  <= row_reg - ROW_W'(r_eff);
            ccol1_reg  <= col_reg - CW'(r_eff);
            flags1_reg <= flags0;
            fwd_cs_reg <= cs1;
            fwd_ls_reg <= pix1_reg;
        end
    end

    // ---------------- stage 2: horizontal running sum ----------------
    always_comb
    begin
        hsum_next = (flags2_reg.col_zero ? HSW'(0) : hsum_reg)
                  - (flags2_reg.col_ge_side ? HSW'(recent_reg[cslot2_reg]) : HSW'(0))
                  + HSW'(cs2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            hsum_reg <= '0;
        end
        else
        begin
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= adv2 && flags2_reg.emit;
            end
            if (adv2)
            begin
                hsum_reg <= hsum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cs2_reg    <= cs1;
            cslot2_reg <= cslot1_reg;
            crow2_reg  <= crow1_reg;
            ccol2_reg  <= ccol1_reg;
            flags2_reg <= flags1_reg;
        end
        if (adv2)
        begin
            recent_reg[cslot2_reg] <= cs2_reg;
            sum3_reg               <= hsum_next;
            crow3_reg              <= crow2_reg;
            ccol3_reg              <= ccol2_reg;
            last3_reg              <= flags2_reg.last;
        end
    end

    // ---------------- stage 3: divide and output ----------------
    bfm_div #(
        .SUM_W (HSW),
        .COL_W (CW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v3_reg),
        .in_ready   (div_ready),
        .sum        (sum3_reg),
        .radius     ((bfm_pkg::RIDX_W)'(r_eff)),
        .crow       (crow3_reg),
        .ccol       (ccol3_reg),
        .last       (last3_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mean_value (mean_value),
        .centre_row (centre_row),
        .centre_col (centre_col),
        .frame_last (frame_last)
    );

    // ---------------- checks ----------------
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last)
        else $error("column counter beyond image width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_last)
        else $error("row counter beyond image height");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(slot_reg) <= side_m1) && (SW'(cslot_reg) <= side_m1))
        else $error("row or column slot beyond window side");

    a_base_match: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg == LAW'(slot_reg * MAX_WIDTH))
        else $error("line store base out of step with row slot");

    a_fwd_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && v1_reg && (col1_reg == col_reg)) |=> fwd_cs_hit_reg && v1_reg)
        else $error("column sum forward not captured");

endmodule

@@ rtl/bfm_ram.sv @@
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and a write of one entry in the same cycle return the old data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bfm_div.sv @@
module bfm_div #(
    parameter int SUM_W = 16,
    parameter int COL_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SUM_W-1:0]            sum,
    input  logic [bfm_pkg::RIDX_W-1:0]  radius,
    input  logic [bfm_pkg::ROW_W-1:0]   crow,
    input  logic [COL_W-1:0]            ccol,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bfm_pkg::PIX_W-1:0]   mean_value,
    output logic [bfm_pkg::ROW_W-1:0]   centre_row,
    output logic [COL_W-1:0]            centre_col,
    output logic                        frame_last
);

    localparam int PROD_W = SUM_W + bfm_pkg::RECIP_W;

    logic                      out_valid_reg;
    logic [bfm_pkg::PIX_W-1:0] mean_reg;
    logic [bfm_pkg::PIX_W-1:0] mean_next;
    logic [bfm_pkg::ROW_W-1:0] crow_reg;
    logic [COL_W-1:0]          ccol_reg;
    logic                      last_reg;
    logic [PROD_W-1:0]         prod;
    logic                      load;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        prod      = PROD_W'(sum) * PROD_W'(bfm_pkg::RECIP_TABLE[radius]);
        mean_next = prod[bfm_pkg::RECIP_SHIFT +: bfm_pkg::PIX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg <= mean_next;
            crow_reg <= crow;
            ccol_reg <= ccol;
            last_reg <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_value = mean_reg;
    assign centre_row = crow_reg;
    assign centre_col = ccol_reg;
    assign frame_last = last_reg;

endmodule
